### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sws_pkg.sv
// shared types and codes of the stack with search
package sws_pkg;

    // request operation codes
    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_LENGTH = 3'd4
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_RESULT
    } t_state;

    // one result item
    typedef struct packed {
        t_status            status;
        logic signed [31:0] word;
        logic [5:0]         pos;
        logic [6:0]         depth;
    } t_result;

endpackage

### design/sws_ram.sv
// stack entry memory: one write port, one registered read port
module sws_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sws_ctrl.sv
// request sequencer: fill count, memory accesses, search scan
module sws_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_cmd,
    input  logic [31:0]      i_operand,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output sws_pkg::t_result o_res,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output logic [31:0]      o_wdata,
    output logic [AW-1:0]    o_raddr,
    input  logic [31:0]      i_rdata
);

    import sws_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [31:0]   r_key, n_key;
    t_result       r_res, n_res;

    logic          full;
    logic          empty;
    logic [AW-1:0] top_addr;

    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign top_addr = AW'(r_count - CW'(1));

    // state register and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
        r_res <= n_res;
    end

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = AW'(r_count);
        o_wdata     = i_operand;
        o_raddr     = '0;
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = (r_state == S_RESULT);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.status = ST_OK;
                    n_res.word   = '0;
                    n_res.pos    = '0;
                    n_res.depth  = 7'(r_count);
                    n_state      = S_RESULT;
                    unique case (i_cmd)
                        CMD_PUSH: begin
                            if (full) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                o_we        = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_res.depth = 7'(r_count + CW'(1));
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                o_raddr     = top_addr;
                                n_count     = r_count - CW'(1);
                                n_res.depth = 7'(r_count - CW'(1));
                                n_state     = S_READ;
                            end
                        end
                        CMD_PEEK: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                o_raddr = top_addr;
                                n_state = S_READ;
                            end
                        end
                        CMD_SEARCH: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                o_raddr = '0;
                                n_idx   = '0;
                                n_key   = i_operand;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // length and unused codes change nothing
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res.word = i_rdata;
                n_state    = S_RESULT;
            end
            S_SCAN: begin
                // compare the entry read last cycle, lowest position first
                priority if (i_rdata == r_key) begin
                    n_res.pos = 6'(r_idx);
                    n_state   = S_RESULT;
                end else if (r_idx == top_addr) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state      = S_RESULT;
                end else begin
                    o_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

### design/stack_with_search.sv
// top level of the lifo stack with linear search
//
// Requests arrive on a valid/ready channel (i_in_valid, o_in_ready) with a
// command code and a signed 32-bit operand. Every request gives exactly one
// result on the output valid/ready channel (o_out_valid, i_out_ready):
// status, popped or peeked word, search position and the entry count.
// Requests are handled one at a time by a sequencer around a single entry
// memory with a registered read port.
// Push, length and any empty or full case go straight to the result state.
// Pop and peek pass through a read state that waits for the memory read.
// Search reads one entry per cycle from the bottom and stops at the first
// match or, without a match, after the top entry.
// Results go into an output register, so a request is taken while a result
// still waits; a held result stalls the sequencer only when the next result
// is ready and the output register is still full.
// Synchronous active-low reset empties the stack and drops any pending
// result; memory contents are not cleared.
`include "assert_macros.svh"

module stack_with_search #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_operand,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_word_out,
    output logic [5:0]         o_found_position,
    output logic [6:0]         o_depth_now
);

    import sws_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          res_valid;
    logic          out_free;
    t_result       res;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic          r_out_valid;
    t_result       r_out;

    // sequencer
    sws_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_operand   (i_operand),
        .o_res_valid (res_valid),
        .i_res_ready (out_free),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // entry memory
    sws_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_word_out       = r_out.word;
    assign o_found_position = r_out.pos;
    assign o_depth_now      = r_out.depth;

    // checks
    `SWS_ASSERT_NEXT(a_res_loads_out, i_clk, i_rst_n, res_valid && out_free, o_out_valid, "result lost")
    `SWS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")
    `SWS_ASSERT_NOW(a_no_word_on_fail, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_word_out == '0, "word on failed request")
    `SWS_ASSERT_NOW(a_no_pos_on_miss, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_found_position == '0, "position on failed request")

endmodule

### verif/stack_with_search_tb.sv
// self-checking bench for the lifo stack with search: predicted results against the dut
`timescale 1ns / 1ps

module stack_with_search_tb;
    import sws_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 80;

    // command codes outside the defined set, handled as length
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // stack contents mirror and queue of predicted results
    class lifo_predictor;
        logic signed [31:0] words [DEPTH];
        int                 count;
        t_result            pending_results [$];
        int                 errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int fill();
            return count;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic signed [31:0] stored_word(int idx);
            return words[idx];
        endfunction

        // work out the result of one accepted request
        function void note_request(logic [2:0] cmd, logic signed [31:0] operand);
            t_result r;
            bit      hit;
            r.status = ST_OK;
            r.word   = '0;
            r.pos    = '0;
            hit      = 1'b0;
            case (cmd)
                CMD_PUSH: begin
                    if (count >= DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        words[count] = operand;
                        count++;
                    end
                end
                CMD_POP: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        count--;
                        r.word = words[count];
                    end
                end
                CMD_PEEK: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else r.word = words[count - 1];
                end
                CMD_SEARCH: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // lowest matching position wins
                        for (int k = 0; k < count; k++) begin
                            if (!hit && words[k] == operand) begin
                                hit   = 1'b1;
                                r.pos = 6'(k);
                            end
                        end
                        if (!hit) r.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
            r.depth = 7'(count);
            pending_results.push_back(r);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [1:0] status, logic signed [31:0] word,
                                   logic [5:0] pos, logic [6:0] depth);
            t_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d word %0d pos %0d depth %0d",
                         $time, status, word, pos, depth);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                errors++;
            end
            if (word !== e.word) begin
                $display("%0t: word_out expected %0d actual %0d", $time, e.word, word);
                errors++;
            end
            if (pos !== e.pos) begin
                $display("%0t: found_position expected %0d actual %0d", $time, e.pos, pos);
                errors++;
            end
            if (depth !== e.depth) begin
                $display("%0t: depth_now expected %0d actual %0d", $time, e.depth, depth);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               o_in_ready;
    logic [2:0]         in_cmd;
    logic signed [31:0] in_operand;
    logic               o_out_valid;
    logic               out_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_word_out;
    logic [5:0]         o_found_position;
    logic [6:0]         o_depth_now;

    lifo_predictor      model = new();
    bit                 in_idle_on;
    bit                 out_idle_on;
    int                 out_stall_left;
    int                 cycles;

    stack_with_search #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (in_cmd),
        .i_operand        (in_operand),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_status         (o_status),
        .o_word_out       (o_word_out),
        .o_found_position (o_found_position),
        .o_depth_now      (o_depth_now)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side back-pressure in random bursts while idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready      <= 1'b0;
            out_stall_left <= 0;
        end else if (out_stall_left > 0) begin
            out_ready      <= 1'b0;
            out_stall_left <= out_stall_left - 1;
        end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
            out_ready      <= 1'b0;
            out_stall_left <= $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready)
            model.check_result(o_status, o_word_out, o_found_position, o_depth_now);
    end

    // one request, held until taken, with an optional idle gap ahead of it
    task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] operand);
        int gap;
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_cmd     <= cmd;
        in_operand <= operand;
        do @(posedge i_clk); while (!o_in_ready);
        model.note_request(cmd, operand);
    endtask

    // operand mix: extremes, a small pool for repeats, full random
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            4, 5, 6: return 32'($urandom_range(0, 7)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    // search operand, mostly a word that is on the stack
    function automatic logic signed [31:0] pick_search_word();
        if (model.fill() > 0 && $urandom_range(0, 9) < 6)
            return model.stored_word($urandom_range(0, model.fill() - 1));
        return pick_word();
    endfunction

    // random command mix, biased toward growth while the stack is shallow
    task automatic send_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (model.fill() < 8 && r < 20) r = 0;
            if (r < 40) send_request(CMD_PUSH, pick_word());
            else if (r < 60) send_request(CMD_POP, pick_word());
            else if (r < 70) send_request(CMD_PEEK, pick_word());
            else if (r < 90) send_request(CMD_SEARCH, pick_search_word());
            else if (r < 96) send_request(CMD_LENGTH, pick_word());
            else send_request(3'($urandom_range(5, 7)), pick_word());
        end
    endtask

    // fill to the top, hit overflow, probe the full stack
    task automatic fill_and_probe();
        while (model.fill() < DEPTH) begin
            send_request(CMD_PUSH, pick_word());
            if ($urandom_range(0, 9) == 0) send_request(CMD_SEARCH, pick_search_word());
        end
        repeat (3) send_request(CMD_PUSH, pick_word());
        send_request(CMD_SEARCH, model.stored_word(DEPTH - 1));
        send_request(CMD_SEARCH, model.stored_word(0));
        send_request(CMD_SEARCH, $urandom);
        send_request(CMD_PEEK, '0);
        send_request(CMD_LENGTH, '0);
    endtask

    // drain to empty, then underflow
    task automatic drain_and_probe();
        while (model.fill() > 0) begin
            send_request(CMD_POP, pick_word());
            if ($urandom_range(0, 9) == 0) send_request(CMD_PEEK, pick_word());
        end
        repeat (2) send_request(CMD_POP, pick_word());
        send_request(CMD_PEEK, pick_word());
        send_request(CMD_SEARCH, pick_word());
    endtask

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        in_valid    <= 1'b0;
        in_cmd      <= CMD_LENGTH;
        in_operand  <= '0;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        cycles      = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty stack cases, extremes, duplicates, spare codes
        send_request(CMD_LENGTH, '0);
        send_request(CMD_POP, '0);
        send_request(CMD_PEEK, '0);
        send_request(CMD_SEARCH, 32'sd5);
        send_request(CMD_PUSH, 32'sh8000_0000);
        send_request(CMD_PUSH, 32'sh7fff_ffff);
        send_request(CMD_PUSH, 32'sh0000_0000);
        send_request(CMD_PUSH, -32'sd1);
        send_request(CMD_PUSH, 32'sh7fff_ffff);
        send_request(CMD_PEEK, '0);
        send_request(CMD_SEARCH, 32'sh7fff_ffff);
        send_request(CMD_SEARCH, 32'sh8000_0000);
        send_request(CMD_SEARCH, -32'sd1);
        send_request(CMD_SEARCH, 32'sd12345);
        send_request(CMD_LENGTH, -32'sd1);
        send_request(CMD_SPARE_5, 32'sh7fff_ffff);
        send_request(CMD_SPARE_6, 32'sh8000_0000);
        send_request(CMD_SPARE_7, -32'sd1);
        send_request(CMD_POP, '0);
        send_request(CMD_POP, '0);
        send_request(CMD_PEEK, '0);

        // random traffic with idling on both sides
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        send_random(250);

        // hold off until every result is back
        in_valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);

        fill_and_probe();
        drain_and_probe();
        send_random(250);

        // last stretch without idling
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        send_random(100);
        in_valid <= 1'b0;

        while (model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (model.errors == 0 && model.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/sws_pkg.sv
design/sws_ram.sv
design/sws_ctrl.sv
design/stack_with_search.sv
verif/stack_with_search_tb.sv
